// ===== sv/stma_pkg.sv =====
// Shared types and codes for the sparse triplet matrix adder.
// No dependencies; imported by the interfaces and all modules.
package stma_pkg;

  localparam int RowW    = 7;
  localparam int ColW    = 7;
  localparam int ValW    = 32;
  localparam int OpW     = 2;
  localparam int StatW   = 2;
  localparam int DimW    = 8;
  localparam int CfgIdxW = 2;

  localparam int MaxResults = 64;
  localparam int ResCntW    = $clog2(MaxResults + 1);

  localparam logic [OpW-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OpW-1:0] OP_RUN    = 2'd2;

  localparam logic [StatW-1:0] ST_ENTRY    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY    = 2'd1;
  localparam logic [StatW-1:0] ST_MISMATCH = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_FIRST_ROWS  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRST_COLS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SECOND_ROWS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SECOND_COLS = 2'd3;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [ValW-1:0] val;
  } triplet_t;

  typedef struct packed {
    logic load;
    logic clear;
  } list_ctrl_t;

endpackage

// ===== sv/stma_ifs.sv =====
// Valid/ready channel interfaces: configuration, command and result.
// Depends on stma_pkg.
interface stma_cfg_if import stma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface stma_in_if import stma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic [RowW-1:0]        row_index;
  logic [ColW-1:0]        col_index;
  logic signed [ValW-1:0] entry_value;
  modport source (output valid, op, row_index, col_index, entry_value, input ready);
  modport sink (input valid, op, row_index, col_index, entry_value, output ready);
endinterface

interface stma_out_if import stma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RowW-1:0]        out_row;
  logic [ColW-1:0]        out_col;
  logic signed [ValW-1:0] out_value;
  logic [StatW-1:0]       status;
  logic                   last;
  modport source (output valid, out_row, out_col, out_value, status, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, status, last, output ready);
endinterface

// ===== sv/stma_list.sv =====
// Triplet list: memory with one write port, a registered read port and a fill count.
// Depends on stma_pkg.
module stma_list import stma_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int CW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  list_ctrl_t    ctrl,
  input  triplet_t      wr_data,
  input  logic [AW-1:0] rd_addr,
  output triplet_t      rd_data,
  output logic [CW-1:0] count
);

  triplet_t mem [DEPTH];
  logic     has_room;

  assign has_room = count < CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (ctrl.load && has_room) begin
      mem[count[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.load && has_room) begin
      count <= count + CW'(1);
    end
  end

endmodule

// ===== sv/sparse_triplet_matrix_add.sv =====
// Sparse matrix adder: merges two row-major triplet lists into their sum.
// Load transactions are accepted back to back while idle. Each merge step of a run
// reads the list memories, then compares and adds in the shared unit; a final
// state then sends the last result. Steps stall while the result register is full.
// Reset clears sequencer, list counts and dimension registers; list memories
// are not cleared. Depends on stma_pkg, stma_ifs and stma_list.
module sparse_triplet_matrix_add import stma_pkg::*; #(
  parameter int MAX_NONZERO = 32
) (
  input logic      clk,
  input logic      rst,
  stma_cfg_if.sink cfg,
  stma_in_if.sink  cmd,
  stma_out_if.source res
);

  localparam int AW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
  localparam int CW = $clog2(MAX_NONZERO + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0]         state;
  logic [DimW-1:0]    first_rows, first_cols, second_rows, second_cols;
  logic [CW-1:0]      i, j, cnt_a, cnt_b;
  logic [ResCntW-1:0] n;
  logic               mism_run;
  logic               hold_valid;
  triplet_t           hold;
  logic               ov;
  triplet_t           o_trip;
  logic [StatW-1:0]   o_status;
  logic               o_last;

  list_ctrl_t a_ctrl, b_ctrl;
  triplet_t   wr_trip, rd_a, rd_b, cand;
  logic       cmd_acc, a_has, b_has, a_lt, keq, take_a, take_b, take_eq;
  logic       cand_ok, out_free, step_go, fin_go, mism, ov_set;
  logic [ValW-1:0] sum;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_acc   = cmd.valid && cmd.ready;

  assign wr_trip = '{row: cmd.row_index, col: cmd.col_index, val: cmd.entry_value};

  assign a_ctrl.load  = cmd_acc && (cmd.op == OP_LOAD_A);
  assign b_ctrl.load  = cmd_acc && (cmd.op == OP_LOAD_B);
  assign a_ctrl.clear = fin_go;
  assign b_ctrl.clear = fin_go;

  stma_list #(.DEPTH(MAX_NONZERO), .AW(AW), .CW(CW)) u_list_a (
    .clk(clk), .rst(rst), .ctrl(a_ctrl), .wr_data(wr_trip),
    .rd_addr(i[AW-1:0]), .rd_data(rd_a), .count(cnt_a)
  );

  stma_list #(.DEPTH(MAX_NONZERO), .AW(AW), .CW(CW)) u_list_b (
    .clk(clk), .rst(rst), .ctrl(b_ctrl), .wr_data(wr_trip),
    .rd_addr(j[AW-1:0]), .rd_data(rd_b), .count(cnt_b)
  );

  // shared compare/add unit
  always_comb begin
    mism    = (first_rows != second_rows) || (first_cols != second_cols);
    a_has   = i < cnt_a;
    b_has   = j < cnt_b;
    a_lt    = {rd_a.row, rd_a.col} < {rd_b.row, rd_b.col};
    keq     = {rd_a.row, rd_a.col} == {rd_b.row, rd_b.col};
    sum     = rd_a.val + rd_b.val;
    take_eq = a_has && b_has && keq;
    take_a  = a_has && !take_eq && (!b_has || a_lt);
    take_b  = b_has && !take_eq && !take_a;
    if (take_eq) begin
      cand = '{row: rd_a.row, col: rd_a.col, val: sum};
    end else if (take_a) begin
      cand = rd_a;
    end else begin
      cand = rd_b;
    end
    cand_ok  = !(take_eq && (sum == '0)) && (n < ResCntW'(MaxResults));
    out_free = !ov || res.ready;
    step_go  = (state == S_MERGE) && !(cand_ok && hold_valid && !out_free);
    fin_go   = (state == S_FINAL) && out_free;
    ov_set   = (step_go && cand_ok && hold_valid) || fin_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ov          <= 1'b0;
      hold_valid  <= 1'b0;
      mism_run    <= 1'b0;
      i           <= '0;
      j           <= '0;
      n           <= '0;
      first_rows  <= '0;
      first_cols  <= '0;
      second_rows <= '0;
      second_cols <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FIRST_ROWS:  first_rows  <= cfg.data;
          REG_FIRST_COLS:  first_cols  <= cfg.data;
          REG_SECOND_ROWS: second_rows <= cfg.data;
          REG_SECOND_COLS: second_cols <= cfg.data;
          default: ;
        endcase
      end
      if (ov && res.ready && !ov_set) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_acc && (cmd.op == OP_RUN)) begin
            i          <= '0;
            j          <= '0;
            n          <= '0;
            hold_valid <= 1'b0;
            mism_run   <= mism;
            state      <= mism ? S_FINAL : S_FETCH;
          end
        end
        S_FETCH: begin
          state <= (a_has || b_has) ? S_MERGE : S_FINAL;
        end
        S_MERGE: begin
          if (step_go) begin
            if (take_a || take_eq) begin
              i <= i + CW'(1);
            end
            if (take_b || take_eq) begin
              j <= j + CW'(1);
            end
            if (cand_ok) begin
              if (hold_valid) begin
                ov       <= 1'b1;
                o_trip   <= hold;
                o_status <= ST_ENTRY;
                o_last   <= 1'b0;
              end
              hold       <= cand;
              hold_valid <= 1'b1;
              n          <= n + ResCntW'(1);
            end
            state <= S_FETCH;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            ov     <= 1'b1;
            o_last <= 1'b1;
            if (mism_run) begin
              o_trip   <= '0;
              o_status <= ST_MISMATCH;
            end else if (hold_valid) begin
              o_trip   <= hold;
              o_status <= ST_ENTRY;
            end else begin
              o_trip   <= '0;
              o_status <= ST_EMPTY;
            end
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid     = ov;
  assign res.out_row   = o_trip.row;
  assign res.out_col   = o_trip.col;
  assign res.out_value = o_trip.val;
  assign res.status    = o_status;
  assign res.last      = o_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= CW'(MAX_NONZERO)) && (cnt_b <= CW'(MAX_NONZERO)))
    else $error("list count beyond capacity");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status != ST_ENTRY)) |-> res.last)
    else $error("status result not marked last");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("pending entry left after run");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (cnt_a == '0) && (cnt_b == '0))
    else $error("lists not cleared after run");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sparse_triplet_matrix_add: directed table, then random merge runs.
// Depends on stma_pkg, stma_ifs and the adder RTL; predicts each sum entry in SystemVerilog.
module tb;
  import stma_pkg::*;

  localparam int ListDepth   = 32;
  localparam int QuietLimit  = 2000;
  localparam int ScriptLen   = 24;
  localparam int RandomCmds  = 236;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [ValW-1:0]  val;
    logic [StatW-1:0] status;
    logic             last;
  } sum_entry_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [DimW-1:0]    dim;
    logic [OpW-1:0]     op;
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    col;
    logic [ValW-1:0]    val;
    bit                 typed;
    logic [StatW-1:0]   typed_status;
  } step_t;

  logic clk;
  logic rst;

  stma_cfg_if cfg();
  stma_in_if  cmd();
  stma_out_if res();

  sparse_triplet_matrix_add #(.MAX_NONZERO(ListDepth)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd(cmd),
    .res(res)
  );

  // adder model state
  triplet_t        first_store [ListDepth];
  triplet_t        second_store[ListDepth];
  int              first_fill;
  int              second_fill;
  logic [DimW-1:0] dims[4];

  sum_entry_t pending_sums[$];
  sum_entry_t run_sums[$];
  sum_entry_t head;

  int  errors;
  int  checked;
  int  cmd_count;
  int  run_count;
  int  reg_writes;
  int  quiet;
  bit  calm;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic step_t ld(logic [OpW-1:0] op, logic [RowW-1:0] row,
                               logic [ColW-1:0] col, logic [ValW-1:0] val);
    step_t s;
    s = '0;
    s.op = op;
    s.row = row;
    s.col = col;
    s.val = val;
    return s;
  endfunction

  function automatic step_t cf(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] dim);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.dim = dim;
    return s;
  endfunction

  function automatic step_t go_expect(logic [StatW-1:0] st);
    step_t s;
    s = ld(OP_RUN, '0, '0, '0);
    s.typed = 1'b1;
    s.typed_status = st;
    return s;
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      default: return DimW'($urandom_range(0, 128));
    endcase
  endfunction

  function automatic void emit_sum(logic [RowW-1:0] row, logic [ColW-1:0] col,
                                   logic [ValW-1:0] val, logic [StatW-1:0] st);
    if (run_sums.size() < MaxResults)
      run_sums.push_back('{row: row, col: col, val: val, status: st, last: 1'b0});
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Apply one accepted command to the model; queue the sum entries a run produces.
  task automatic predict(logic [OpW-1:0] op, logic [RowW-1:0] row, logic [ColW-1:0] col,
                         logic [ValW-1:0] val, bit typed, logic [StatW-1:0] typed_st);
    int i;
    int j;
    triplet_t a;
    triplet_t b;
    logic [ValW-1:0] total;
    case (op)
      OP_LOAD_A: begin
        if (first_fill < ListDepth) begin
          first_store[first_fill] = '{row: row, col: col, val: val};
          first_fill++;
        end
      end
      OP_LOAD_B: begin
        if (second_fill < ListDepth) begin
          second_store[second_fill] = '{row: row, col: col, val: val};
          second_fill++;
        end
      end
      OP_RUN: begin
        run_sums.delete();
        if (dims[REG_FIRST_ROWS] != dims[REG_SECOND_ROWS] ||
            dims[REG_FIRST_COLS] != dims[REG_SECOND_COLS]) begin
          emit_sum('0, '0, '0, ST_MISMATCH);
        end else begin
          i = 0;
          j = 0;
          while (i < first_fill && j < second_fill) begin
            a = first_store[i];
            b = second_store[j];
            if ({a.row, a.col} < {b.row, b.col}) begin
              emit_sum(a.row, a.col, a.val, ST_ENTRY);
              i++;
            end else if ({b.row, b.col} < {a.row, a.col}) begin
              emit_sum(b.row, b.col, b.val, ST_ENTRY);
              j++;
            end else begin
              total = a.val + b.val;
              if (total != '0) emit_sum(a.row, a.col, total, ST_ENTRY);
              i++;
              j++;
            end
          end
          for (; i < first_fill; i++)
            emit_sum(first_store[i].row, first_store[i].col, first_store[i].val, ST_ENTRY);
          for (; j < second_fill; j++)
            emit_sum(second_store[j].row, second_store[j].col, second_store[j].val, ST_ENTRY);
          if (run_sums.size() == 0) emit_sum('0, '0, '0, ST_EMPTY);
        end
        run_sums[run_sums.size() - 1].last = 1'b1;
        first_fill = 0;
        second_fill = 0;
        if (typed) begin
          pending_sums.push_back('{row: '0, col: '0, val: '0, status: typed_st, last: 1'b1});
        end else begin
          foreach (run_sums[k]) pending_sums.push_back(run_sums[k]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic issue(logic [OpW-1:0] op, logic [RowW-1:0] row, logic [ColW-1:0] col,
                       logic [ValW-1:0] val, bit typed, logic [StatW-1:0] typed_st);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      cmd.valid <= 1'b0;
    end
    @(negedge clk);
    cmd.valid       <= 1'b1;
    cmd.op          <= op;
    cmd.row_index   <= row;
    cmd.col_index   <= col;
    cmd.entry_value <= val;
    do @(posedge clk); while (!cmd.ready);
    predict(op, row, col, val, typed, typed_st);
    if (op != OpUnused) cmd_count++;
    if (op == OP_RUN) run_count++;
  endtask

  // Drain all sum entries, then give the sequencer time to go idle.
  task automatic settle();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    dims[idx] = data;
    reg_writes++;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected transaction: status %0d row %0d col %0d value 0x%0h",
               res.status, res.out_row, res.out_col, res.out_value);
        errors++;
      end else begin
        head = pending_sums.pop_front();
        check_field("out_row", 32'(head.row), 32'(res.out_row));
        check_field("out_col", 32'(head.col), 32'(res.out_col));
        check_field("out_value", head.val, res.out_value);
        check_field("status", 32'(head.status), 32'(res.status));
        check_field("last", 32'(head.last), 32'(res.last));
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QuietLimit);
    $display("sparse_triplet_matrix_add verification failed");
    $finish;
  end

  // result-side backpressure
  initial begin
    int  stall;
    bit  steady;
    steady = 1'b0;
    res.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        res.ready <= 1'b0;
      end
      @(negedge clk);
      res.ready <= 1'b1;
      do @(posedge clk); while (!(res.valid && !rst));
    end
  end

  initial begin
    step_t            script[ScriptLen];
    triplet_t         a_q[$];
    triplet_t         b_q[$];
    triplet_t         swap_q[$];
    triplet_t         t;
    logic [13:0]      pos;
    logic [DimW-1:0]  d_rows;
    logic [DimW-1:0]  d_cols;
    int               key;
    int               span;
    int               npos;
    int               kind;
    int               choice;
    int               phase;
    bit               overflow;

    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    cmd.valid = 1'b0;
    cmd.op = OP_LOAD_A;
    cmd.row_index = '0;
    cmd.col_index = '0;
    cmd.entry_value = '0;
    errors = 0;
    checked = 0;
    cmd_count = 0;
    run_count = 0;
    reg_writes = 0;
    quiet = 0;
    calm = 1'b0;
    first_fill = 0;
    second_fill = 0;
    foreach (dims[k]) dims[k] = '0;

    script = '{
      go_expect(ST_EMPTY),
      ld(OpUnused, 7'd127, 7'd127, 32'hFFFF_FFFF),
      cf(REG_FIRST_ROWS, 8'd128),
      ld(OP_LOAD_A, 7'd0, 7'd0, 32'h0000_0001),
      go_expect(ST_MISMATCH),
      cf(REG_SECOND_ROWS, 8'd128),
      cf(REG_FIRST_COLS, 8'd128),
      cf(REG_SECOND_COLS, 8'd128),
      ld(OP_LOAD_A, 7'd0, 7'd0, 32'h7FFF_FFFF),
      ld(OP_LOAD_B, 7'd0, 7'd0, 32'h0000_0001),
      ld(OP_LOAD_A, 7'd0, 7'd5, -32'sd5),
      ld(OP_LOAD_B, 7'd0, 7'd5, 32'sd5),
      ld(OP_LOAD_A, 7'd3, 7'd2, 32'h0000_0000),
      ld(OP_LOAD_B, 7'd3, 7'd1, 32'h8000_0000),
      ld(OP_LOAD_A, 7'd127, 7'd127, 32'hFFFF_FFFF),
      ld(OP_LOAD_B, 7'd127, 7'd0, 32'h8000_0000),
      ld(OpUnused, 7'd0, 7'd0, 32'h0000_0000),
      ld(OP_RUN, 7'd0, 7'd0, 32'h0000_0000),
      go_expect(ST_EMPTY),
      ld(OP_LOAD_A, 7'd1, 7'd1, 32'sd10),
      ld(OP_LOAD_B, 7'd1, 7'd1, -32'sd10),
      go_expect(ST_EMPTY),
      cf(REG_FIRST_COLS, 8'd0),
      go_expect(ST_MISMATCH)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        settle();
        write_reg(script[k].idx, script[k].dim);
      end else begin
        issue(script[k].op, script[k].row, script[k].col, script[k].val,
              script[k].typed, script[k].typed_status);
      end
    end

    phase = 0;
    while (cmd_count < ScriptLen + RandomCmds) begin
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 0 || $urandom_range(0, 3) == 0) begin
        settle();
        d_rows = pick_dim();
        d_cols = pick_dim();
        write_reg(REG_FIRST_ROWS, d_rows);
        write_reg(REG_FIRST_COLS, d_cols);
        if ($urandom_range(0, 5) == 0) begin
          d_rows = pick_dim();
          d_cols = pick_dim();
        end
        write_reg(REG_SECOND_ROWS, d_rows);
        write_reg(REG_SECOND_COLS, d_cols);
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise: any op, any position order
        repeat ($urandom_range(1, 12))
          issue(OpW'($urandom_range(0, 3)), RowW'($urandom()), ColW'($urandom()),
                pick_value(), 1'b0, ST_ENTRY);
      end else begin
        overflow = (kind == 1);
        npos = overflow ? $urandom_range(34, 44) : $urandom_range(0, 10);
        span = ($urandom_range(0, 2) == 0) ? 3 : 16384 / (npos + 1);
        key = -1;
        a_q.delete();
        b_q.delete();
        for (int p = 0; p < npos; p++) begin
          key = key + int'($urandom_range(1, span));
          if (key > 16383) break;
          pos = 14'(key);
          t.row = pos[13:7];
          t.col = pos[6:0];
          t.val = pick_value();
          choice = $urandom_range(0, 3);
          if (overflow && choice == 1) choice = 0;
          if (choice != 1) a_q.push_back(t);
          if (choice != 0) begin
            if (choice == 3) t.val = -t.val;
            else if (choice == 2) t.val = pick_value();
            b_q.push_back(t);
          end
        end
        if (overflow && $urandom_range(0, 1) == 1) begin
          swap_q = a_q;
          a_q = b_q;
          b_q = swap_q;
        end
        while (a_q.size() + b_q.size() > 0) begin
          if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(0, 1) == 1)) begin
            t = a_q.pop_front();
            issue(OP_LOAD_A, t.row, t.col, t.val, 1'b0, ST_ENTRY);
          end else begin
            t = b_q.pop_front();
            issue(OP_LOAD_B, t.row, t.col, t.val, 1'b0, ST_ENTRY);
          end
        end
      end
      issue(OP_RUN, RowW'($urandom()), ColW'($urandom()), $urandom(), 1'b0, ST_ENTRY);
      phase++;
    end

    @(negedge clk);
    cmd.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d commands, %0d additions and %0d dimension writes;",
             cmd_count, run_count, reg_writes);
    $display("%0d result transactions compared, %0d mismatches.", checked, errors);
    if (errors == 0)
      $display("sparse_triplet_matrix_add verification clean");
    else
      $display("sparse_triplet_matrix_add verification failed");
    $finish;
  end

endmodule
